// ===== hdl/assert_macros.svh =====
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bfha_pkg.sv =====
package bfha_pkg;
  localparam int TableEntries = 16;
  localparam int HeaderBytes  = 24;
  localparam int AddrBits     = 24;
  localparam int IdxBits      = $clog2(TableEntries);
  localparam int CntBits      = $clog2(TableEntries + 1);

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [AddrBits:0]   wide_t;
  typedef logic [AddrBits+1:0] ext_t;
  typedef logic [IdxBits-1:0]  idx_t;
  typedef logic [CntBits-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_ZERO = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam addr_t HdrA = addr_t'(HeaderBytes);
  localparam wide_t HdrW = wide_t'(HeaderBytes);
  localparam addr_t AddrMax = '1;
endpackage

// ===== hdl/best_fit_heap_allocator.sv =====
// Best-fit heap allocator with coalescing over a 16-entry address-ordered
// free table. One item at a time; in_ready is low while an item is worked.
// Allocate: scan for an exact fit or the smallest block that can be split;
// an exact-fit block is removed by shifting each later entry down, a larger
// block is split, and with no fit the heap top is bumped. Free: scan to find
// the slot, shift entries up, insert, then up to two merge steps (with the
// next, then previous entry) that may shift the tail down. The scan reads
// one table entry per cycle and every shift step moves one entry through the
// single write port of the free table. The result is held in an output
// register; the next item is taken once it has been delivered. heap_limit is
// written through cfg_ while the block is idle; reset value is all ones.
module best_fit_heap_allocator import bfha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  addr_t       in_request_size,
  input  addr_t       in_payload_address,
  output logic        out_valid,
  input  logic        out_ready,
  output addr_t       out_result_address,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  addr_t       cfg_heap_limit
);

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_ASPLIT, S_DROP, S_FSCAN, S_FSHIFT, S_FINS,
    S_MNEXT, S_MPREV_RD, S_MPREV, S_DONE
  } state_t;

  addr_t tb_base [TableEntries];
  addr_t tb_size [TableEntries];

  state_t  state_r;
  cnt_t    cnt_r;
  cnt_t    i_r;
  cnt_t    p_r;
  cnt_t    best_r;
  logic    have_best_r;
  addr_t   best_size_r;
  addr_t   best_base_r;
  logic    cmd_r;
  addr_t   size_r;
  addr_t   base_r;
  addr_t   top_r;
  addr_t   limit_r;
  addr_t   res_r;
  status_t st_r;
  logic    ov_r;
  addr_t   cur_base_r;
  addr_t   cur_size_r;
  cnt_t    drop_r;

  // read path at index i_r (shift steps read neighbouring entries directly)
  idx_t  rd_idx;
  addr_t rd_base, rd_size;
  always_comb begin
    rd_idx = i_r[IdxBits-1:0];
    rd_base = tb_base[rd_idx];
    rd_size = tb_size[rd_idx];
  end

  wide_t hs;
  wide_t end_cur;
  wide_t sum_sz;
  addr_t sat_sum;
  assign hs = {1'b0, size_r} + HdrW;
  assign end_cur = {1'b0, cur_base_r} + HdrW + {1'b0, cur_size_r};
  assign sum_sz = {1'b0, cur_size_r} + HdrW + {1'b0, rd_size};
  assign sat_sum = sum_sz[AddrBits] ? AddrMax : sum_sz[AddrBits-1:0];

  ext_t bump;
  assign bump = {2'b00, top_r} + {1'b0, hs};

  logic       wr_en;
  idx_t       wr_idx;
  addr_t      wr_base, wr_size;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_result_address = res_r;
  assign out_status = st_r;

  always_comb begin
    wr_en = 1'b0;
    wr_idx = i_r[IdxBits-1:0];
    wr_base = rd_base;
    wr_size = rd_size;
    case (state_r)
      S_ASPLIT: begin
        wr_en = 1'b1;
        wr_idx = best_r[IdxBits-1:0];
        wr_base = best_base_r;
        wr_size = best_size_r - hs[AddrBits-1:0];
      end
      S_DROP: begin
        if (i_r + cnt_t'(1) < cnt_r) begin
          wr_en = 1'b1;
          wr_base = tb_base[IdxBits'(i_r + cnt_t'(1))];
          wr_size = tb_size[IdxBits'(i_r + cnt_t'(1))];
        end
      end
      S_FSHIFT: begin
        if (i_r > p_r) begin
          wr_en = 1'b1;
          wr_base = tb_base[IdxBits'(i_r - cnt_t'(1))];
          wr_size = tb_size[IdxBits'(i_r - cnt_t'(1))];
        end
      end
      S_FINS: begin
        wr_en = 1'b1;
        wr_idx = p_r[IdxBits-1:0];
        wr_base = base_r;
        wr_size = size_r;
      end
      S_MNEXT, S_MPREV: begin
        if (i_r < cnt_r && end_cur == {1'b0, rd_base}) begin
          wr_en = 1'b1;
          wr_idx = p_r[IdxBits-1:0];
          wr_base = cur_base_r;
          wr_size = sat_sum;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tb_base[wr_idx] <= wr_base;
      tb_size[wr_idx] <= wr_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      top_r <= '0;
      limit_r <= AddrMax;
      ov_r <= 1'b0;
      i_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) limit_r <= cfg_heap_limit;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r <= in_command;
            size_r <= in_request_size;
            base_r <= in_payload_address - HdrA;
            i_r <= '0;
            have_best_r <= 1'b0;
            res_r <= '0;
            st_r <= ST_OK;
            if (in_command == CMD_ALLOC) begin
              if (in_request_size == '0) begin
                st_r <= ST_ZERO;
                state_r <= S_DONE;
              end else begin
                state_r <= S_ASCAN;
              end
            end else if (in_payload_address == '0) begin
              state_r <= S_DONE;
            end else if (cnt_r >= cnt_t'(TableEntries)) begin
              st_r <= ST_FULL;
              state_r <= S_DONE;
            end else begin
              state_r <= S_FSCAN;
            end
          end
        end
        S_ASCAN: begin
          if (i_r >= cnt_r) begin
            if (have_best_r) begin
              state_r <= S_ASPLIT;
            end else begin
              if (bump > {2'b00, limit_r}) begin
                st_r <= ST_OOM;
              end else begin
                res_r <= top_r + HdrA;
                top_r <= bump[AddrBits-1:0];
              end
              state_r <= S_DONE;
            end
          end else if ({1'b0, rd_size} > hs) begin
            if (!have_best_r || rd_size < best_size_r) begin
              have_best_r <= 1'b1;
              best_r <= i_r;
              best_size_r <= rd_size;
              best_base_r <= rd_base;
            end
            i_r <= i_r + cnt_t'(1);
          end else if (rd_size >= size_r) begin
            res_r <= rd_base + HdrA;
            drop_r <= i_r;
            state_r <= S_DROP;
          end else begin
            i_r <= i_r + cnt_t'(1);
          end
        end
        S_ASPLIT: begin
          res_r <= best_base_r + HdrA + (best_size_r - hs[AddrBits-1:0]) + HdrA;
          state_r <= S_DONE;
        end
        S_DROP: begin
          if (i_r + cnt_t'(1) < cnt_r) begin
            i_r <= i_r + cnt_t'(1);
          end else begin
            cnt_r <= cnt_r - cnt_t'(1);
            if (cmd_r == CMD_ALLOC) state_r <= S_DONE;
            else if (drop_r == p_r + cnt_t'(1)) begin
              i_r <= p_r - cnt_t'(1);
              state_r <= (p_r != '0) ? S_MPREV_RD : S_DONE;
            end else state_r <= S_DONE;
          end
        end
        S_FSCAN: begin
          if (i_r < cnt_r && rd_base <= base_r) begin
            i_r <= i_r + cnt_t'(1);
          end else begin
            p_r <= i_r;
            i_r <= cnt_r;
            state_r <= S_FSHIFT;
          end
        end
        S_FSHIFT: begin
          if (i_r > p_r) i_r <= i_r - cnt_t'(1);
          else state_r <= S_FINS;
        end
        S_FINS: begin
          cnt_r <= cnt_r + cnt_t'(1);
          cur_base_r <= base_r;
          cur_size_r <= size_r;
          i_r <= p_r + cnt_t'(1);
          state_r <= S_MNEXT;
        end
        S_MNEXT: begin
          if (i_r < cnt_r && end_cur == {1'b0, rd_base}) begin
            drop_r <= i_r;
            state_r <= S_DROP;
          end else if (p_r != '0) begin
            i_r <= p_r - cnt_t'(1);
            state_r <= S_MPREV_RD;
          end else state_r <= S_DONE;
        end
        S_MPREV_RD: begin
          // load previous entry, then current entry is read at i_r
          cur_base_r <= rd_base;
          cur_size_r <= rd_size;
          i_r <= p_r;
          p_r <= p_r - cnt_t'(1);
          state_r <= S_MPREV;
        end
        S_MPREV: begin
          if (i_r < cnt_r && end_cur == {1'b0, rd_base}) begin
            drop_r <= '0;
            state_r <= S_DROP;
          end else state_r <= S_DONE;
        end
        S_DONE: begin
          ov_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/bfha_checker.sv =====
`include "assert_macros.svh"
module bfha_checker import bfha_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input addr_t      out_result_address,
  input logic [1:0] out_status
);
  `ASSERT_IMP(a_no_accept_busy, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
  `ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && out_status != ST_OK, out_result_address == '0, "failure with nonzero address")
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result_address) && $stable(out_status), "result changed while stalled")
  `ASSERT_NXT(a_one_result, clk, rst_n, in_valid && in_ready, !out_valid, "result too early")
endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_result_address(out_result_address), .out_status(out_status)
);
